// ===== rtl/packet_buffer_dedup_range_count_assert.svh =====
// Assertion macros for the packet buffer block.
`ifndef PACKET_BUFFER_DEDUP_RANGE_COUNT_ASSERT_SVH
`define PACKET_BUFFER_DEDUP_RANGE_COUNT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PBDRC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define PBDRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbdrc_pkg.sv =====
// Types and constants shared by the packet buffer modules.
`default_nettype none
package pbdrc_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = OCC_W + 1;
    localparam int CAP_W  = 7;
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int CNT_W  = 7;
    localparam int WORD_W = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_FWD   = 2'd1;
    localparam logic [1:0] REQ_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] source;
        logic [15:0] destination;
        logic [31:0] timestamp;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } pbdrc_in_t;

    typedef struct packed {
        logic             accepted;
        logic             fwd_valid;
        logic [15:0]      fwd_source;
        logic [15:0]      fwd_destination;
        logic [31:0]      fwd_timestamp;
        logic [CNT_W-1:0] match_count;
    } pbdrc_out_t;

endpackage
`default_nettype wire

// ===== rtl/pbdrc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pbdrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pbdrc_match.sv =====
// Shared compare unit: exact packet match for add, destination and range match for count.
`default_nettype none
module pbdrc_match import pbdrc_pkg::*; (
    input  wire pbdrc_in_t          key,
    input  wire logic [WORD_W-1:0]  word,
    output logic                    hit
);

    logic [15:0] w_src;
    logic [15:0] w_dst;
    logic [31:0] w_ts;

    assign w_src = word[63:48];
    assign w_dst = word[47:32];
    assign w_ts  = word[31:0];

    always_comb begin
        case (key.req_type)
            REQ_ADD: begin
                hit = (w_src == key.source) && (w_dst == key.destination)
                      && (w_ts == key.timestamp);
            end
            REQ_COUNT: begin
                hit = (w_dst == key.destination) && (w_ts >= key.start_time)
                      && (w_ts <= key.end_time);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/packet_buffer_dedup_range_count.sv =====
// Top level of the bounded packet FIFO with duplicate filter and range count.
//
// One request is taken at a time; s_ready is high only while the sequencer is idle.
// Add and count scan the stored packets through the packet RAM, one read per cycle,
// into one shared compare unit; a count goes from the scan straight to the done
// state, an add that stores passes through a write state first, and a rejected
// duplicate goes to done as a count does. A forward passes through a read state
// and a data state; a forward on an empty buffer or an undefined request goes
// straight to done. One finished result waits in the output register while the
// next beat is taken; a second finished result holds the sequencer, and with it
// the input, until m_ready takes the first. The capacity register is written by
// cfg_wr_en; zero acts as one, values above the depth act as the depth.
// The packet RAM needs no clearing pass: only occupied slots are ever read.
`default_nettype none
`include "packet_buffer_dedup_range_count_assert.svh"
module packet_buffer_dedup_range_count import pbdrc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pbdrc_in_t        s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pbdrc_out_t            m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_WRITE    = 3'd2;
    localparam logic [2:0] ST_FWD_RD   = 3'd3;
    localparam logic [2:0] ST_FWD_DATA = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    function automatic logic [ADDR_W-1:0] slot_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
        return r[ADDR_W-1:0];
    endfunction

    logic [2:0]        state_reg, state_next;
    pbdrc_in_t         item_reg, item_next;
    logic [ADDR_W-1:0] oldest_reg, oldest_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [OCC_W-1:0]  idx_reg, idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    pbdrc_out_t        res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    pbdrc_out_t        m_data_reg, m_data_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              match_hit;
    logic [CMP_W-1:0]  eff_cap;
    logic              full;

    pbdrc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pbdrc_match u_match (
        .key  (item_reg),
        .word (rd_data),
        .hit  (match_hit)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(DEPTH)) begin
            eff_cap = CMP_W'(DEPTH);
        end else begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign full = (CMP_W'(occ_reg) >= eff_cap) && (occ_reg != '0);

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        oldest_next  = oldest_reg;
        occ_next     = occ_reg;
        cap_next     = cfg_wr_en ? cfg_wr_data : cap_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        hit_next     = hit_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rd_en        = 1'b0;
        rd_addr      = slot_wrap(SUM_W'(oldest_reg) + SUM_W'(idx_reg));
        wr_en        = 1'b0;
        wr_addr      = slot_wrap(SUM_W'(oldest_reg) + SUM_W'(occ_reg));
        wr_data      = {item_reg.source, item_reg.destination, item_reg.timestamp};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    cnt_next  = '0;
                    res_next  = '0;
                    case (s_data.req_type)
                        REQ_ADD, REQ_COUNT: begin
                            state_next = ST_SCAN;
                        end
                        REQ_FWD: begin
                            state_next = (occ_reg != '0) ? ST_FWD_RD : ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_en        = (idx_reg != occ_reg);
                cmp_vld_next = rd_en;
                if (rd_en) begin
                    idx_next = idx_reg + OCC_W'(1);
                end
                if (cmp_vld_reg) begin
                    hit_next = hit_reg | match_hit;
                    cnt_next = cnt_reg + CNT_W'(match_hit);
                end
                if (!rd_en && !cmp_vld_reg) begin
                    if (item_reg.req_type == REQ_ADD) begin
                        state_next = hit_reg ? ST_DONE : ST_WRITE;
                    end else begin
                        res_next.match_count = cnt_reg;
                        state_next           = ST_DONE;
                    end
                end
            end
            ST_WRITE: begin
                wr_en = 1'b1;
                if (full) begin
                    oldest_next = slot_wrap(SUM_W'(oldest_reg) + SUM_W'(1));
                end else begin
                    occ_next = occ_reg + OCC_W'(1);
                end
                res_next.accepted = 1'b1;
                state_next        = ST_DONE;
            end
            ST_FWD_RD: begin
                rd_en      = 1'b1;
                state_next = ST_FWD_DATA;
            end
            ST_FWD_DATA: begin
                res_next.fwd_valid       = 1'b1;
                res_next.fwd_source      = rd_data[63:48];
                res_next.fwd_destination = rd_data[47:32];
                res_next.fwd_timestamp   = rd_data[31:0];
                oldest_next = slot_wrap(SUM_W'(oldest_reg) + SUM_W'(1));
                occ_next    = occ_reg - OCC_W'(1);
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            oldest_reg  <= '0;
            occ_reg     <= '0;
            cap_reg     <= CAP_RESET;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            occ_reg     <= occ_next;
            cap_reg     <= cap_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    `PBDRC_ASSERT_ALWAYS(a_occ_bound, (occ_reg <= OCC_W'(DEPTH)), "occupancy above depth")
    `PBDRC_ASSERT_ALWAYS(a_write_unique, (!wr_en || (!hit_reg && item_reg.req_type == REQ_ADD)), "write of duplicate or non-add beat")
    `PBDRC_ASSERT_NEXT(a_write_occ, wr_en, (occ_reg != '0), "buffer empty after store")
    `PBDRC_ASSERT_ALWAYS(a_fwd_nonempty, (state_reg != ST_FWD_RD || occ_reg != '0), "forward read from empty buffer")

endmodule
`default_nettype wire
